// ----- sv/rtsel_pkg.sv -----
// Shared types and constants for the trap entry and interrupt select unit.
package rtsel_pkg;

  // Item kinds
  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_ASYNC  = 2'd1;
  localparam logic [1:0] KIND_SYNC   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Privilege levels
  localparam logic [1:0] PRIV_U   = 2'd0;
  localparam logic [1:0] PRIV_S   = 2'd1;
  localparam logic [1:0] PRIV_RSV = 2'd2;
  localparam logic [1:0] PRIV_M   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_VEC_MODE = 2'd1;
  localparam logic [1:0] ERR_PRIV     = 2'd2;

  // Vector modes
  localparam logic [1:0] TVEC_DIRECT   = 2'd0;
  localparam logic [1:0] TVEC_VECTORED = 2'd1;

  // Configuration register indexes
  localparam logic [2:0] REG_MTVEC   = 3'd0;
  localparam logic [2:0] REG_STVEC   = 3'd1;
  localparam logic [2:0] REG_MEDELEG = 3'd2;
  localparam logic [2:0] REG_MIDELEG = 3'd3;
  localparam logic [2:0] REG_MIE     = 3'd4;

  // Status word bit positions
  localparam int ST_SIE_BIT  = 1;
  localparam int ST_MIE_BIT  = 3;
  localparam int ST_SPIE_BIT = 5;
  localparam int ST_MPIE_BIT = 7;
  localparam int ST_SPP_BIT  = 8;
  localparam int ST_MPP_LO   = 11;
  localparam int ST_MPP_HI   = 12;

  // Interrupt sources in priority order: MEI, MSI, MTI, SEI, SSI, STI
  localparam int NUM_SRC = 6;
  localparam logic [4:0] PRIO_CAUSE [NUM_SRC] = '{5'd11, 5'd3, 5'd7, 5'd9, 5'd1, 5'd5};

  typedef struct packed {
    logic [31:0] mtvec;
    logic [31:0] stvec;
    logic [31:0] medeleg;
    logic [11:0] mideleg;
    logic [11:0] mie;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  cause_code;
    logic        is_interrupt;
    logic [31:0] fault_pc;
    logic [31:0] fault_value;
    logic [1:0]  cur_priv;
    logic [31:0] cur_status;
    logic [11:0] pending;
  } item_t;

  typedef struct packed {
    logic        irq_valid;
    logic [4:0]  irq_cause;
    logic        global_enable;
    logic        to_supervisor;
    logic [31:0] trap_pc;
    logic [1:0]  new_priv;
    logic [31:0] new_status;
    logic [31:0] saved_value;
    logic [1:0]  trap_error;
  } result_t;

endpackage

// ----- sv/rtsel_cfg_regs.sv -----
// Configuration register file: vector bases, delegation and enable registers.
module rtsel_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output rtsel_pkg::cfg_t    cfg
);
  import rtsel_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MTVEC:   cfg_nxt.mtvec   = cfg_wdata;
        REG_STVEC:   cfg_nxt.stvec   = cfg_wdata;
        REG_MEDELEG: cfg_nxt.medeleg = cfg_wdata;
        REG_MIDELEG: cfg_nxt.mideleg = cfg_wdata[11:0];
        REG_MIE:     cfg_nxt.mie     = cfg_wdata[11:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/rtsel_irq_pick.sv -----
// Priority select of the highest ready interrupt source, machine target first.
module rtsel_irq_pick (
  input  logic [1:0]  cur_priv,
  input  logic [31:0] cur_status,
  input  logic [11:0] pending,
  input  logic [11:0] mideleg,
  input  logic [11:0] mie,
  output logic        irq_valid,
  output logic [4:0]  irq_cause
);
  import rtsel_pkg::*;

  logic [NUM_SRC-1:0] rdy;
  logic [NUM_SRC-1:0] to_m;
  logic [NUM_SRC-1:0] to_s;
  logic               m_en;
  logic               s_en;
  logic               m_hit;
  logic               s_hit;
  logic [4:0]         m_cause;
  logic [4:0]         s_cause;

  assign m_en = (cur_priv != PRIV_M) || cur_status[ST_MIE_BIT];
  assign s_en = (cur_priv != PRIV_S) || cur_status[ST_SIE_BIT];

  always_comb begin
    for (int i = 0; i < NUM_SRC; i++) begin
      rdy[i]  = pending[PRIO_CAUSE[i][3:0]] && mie[PRIO_CAUSE[i][3:0]];
      to_m[i] = !mideleg[PRIO_CAUSE[i][3:0]];
      // Delegated sources never interrupt machine mode
      to_s[i] = mideleg[PRIO_CAUSE[i][3:0]] && (cur_priv != PRIV_M);
    end
  end

  // Walk from lowest priority up so the first ready source wins
  always_comb begin
    m_hit   = 1'b0;
    s_hit   = 1'b0;
    m_cause = '0;
    s_cause = '0;
    for (int i = NUM_SRC - 1; i >= 0; i--) begin
      if (rdy[i] && to_m[i]) begin
        m_hit   = 1'b1;
        m_cause = PRIO_CAUSE[i];
      end
      if (rdy[i] && to_s[i]) begin
        s_hit   = 1'b1;
        s_cause = PRIO_CAUSE[i];
      end
    end
  end

  always_comb begin
    irq_valid = 1'b0;
    irq_cause = '0;
    if (m_en && m_hit) begin
      irq_valid = 1'b1;
      irq_cause = m_cause;
    end else if (s_en && s_hit) begin
      irq_valid = 1'b1;
      irq_cause = s_cause;
    end
  end

endmodule

// ----- sv/rtsel_trap_eval.sv -----
// Single-pass evaluation of one item: interrupt query or trap entry.
module rtsel_trap_eval (
  input  rtsel_pkg::item_t   item,
  input  rtsel_pkg::cfg_t    cfg,
  output rtsel_pkg::result_t res
);
  import rtsel_pkg::*;

  logic        pick_valid;
  logic [4:0]  pick_cause;
  logic        gen;
  logic [15:0] mideleg_ext;
  logic        deleg;
  logic        to_sup;
  logic [31:0] tvec;
  logic [31:0] base;
  logic [31:0] st_s;
  logic [31:0] st_m;

  rtsel_irq_pick u_pick (
    .cur_priv   (item.cur_priv),
    .cur_status (item.cur_status),
    .pending    (item.pending),
    .mideleg    (cfg.mideleg),
    .mie        (cfg.mie),
    .irq_valid  (pick_valid),
    .irq_cause  (pick_cause)
  );

  always_comb begin
    case (item.cur_priv)
      PRIV_M:  gen = item.cur_status[ST_MIE_BIT];
      PRIV_S:  gen = item.cur_status[ST_SIE_BIT];
      PRIV_U:  gen = 1'b1;
      default: gen = 1'b0;
    endcase
  end

  // Interrupt causes above 11 are never delegated
  assign mideleg_ext = {4'b0000, cfg.mideleg};
  assign deleg = item.is_interrupt ?
                 (!item.cause_code[4] && mideleg_ext[item.cause_code[3:0]]) :
                 cfg.medeleg[item.cause_code];
  assign to_sup = (item.cur_priv != PRIV_M) && deleg;
  assign tvec   = to_sup ? cfg.stvec : cfg.mtvec;
  assign base   = {tvec[31:2], 2'b00};

  always_comb begin
    st_s = item.cur_status;
    st_s[ST_SPIE_BIT] = item.cur_status[ST_SIE_BIT];
    st_s[ST_SIE_BIT]  = 1'b0;
    st_s[ST_SPP_BIT]  = (item.cur_priv == PRIV_S);
    st_m = item.cur_status;
    st_m[ST_MPIE_BIT] = item.cur_status[ST_MIE_BIT];
    st_m[ST_MIE_BIT]  = 1'b0;
    st_m[ST_MPP_HI:ST_MPP_LO] = item.cur_priv;
  end

  always_comb begin
    res = '0;
    res.global_enable = gen;
    if (item.kind == KIND_QUERY) begin
      if (item.cur_priv == PRIV_RSV) begin
        res.trap_error = ERR_PRIV;
      end else begin
        res.irq_valid = pick_valid;
        res.irq_cause = pick_cause;
      end
    end else if (item.cur_priv == PRIV_RSV) begin
      // Trap not taken: pass privilege and status through
      res.trap_error = ERR_PRIV;
      res.new_priv   = item.cur_priv;
      res.new_status = item.cur_status;
    end else begin
      res.to_supervisor = to_sup;
      res.new_priv      = to_sup ? PRIV_S : PRIV_M;
      res.new_status    = to_sup ? st_s : st_m;
      res.saved_value   = (item.kind == KIND_SYNC) ? item.fault_value : 32'd0;
      res.trap_pc       = base;
      if (tvec[1:0] == TVEC_VECTORED) begin
        if (item.is_interrupt) begin
          res.trap_pc = base + {25'd0, item.cause_code, 2'b00};
        end
      end else if (tvec[1:0] != TVEC_DIRECT) begin
        res.trap_error = ERR_VEC_MODE;
      end
    end
  end

endmodule

// ----- sv/riscv_trap_entry_and_interrupt_select_unit.sv -----
// Top level of the trap entry and interrupt select unit.
//
// Machine/supervisor trap entry and interrupt selection. Each input beat is
// either an interrupt query (kind 0), an asynchronous interrupt to take
// (kind 1) or a synchronous exception to take (kind 2); kind 3 beats are
// accepted and dropped with no result. A query returns the highest ready
// source among MEI, MSI, MTI, SEI, SSI, STI after delegation, global and
// per-source enables. A trap returns the target mode, handler pc (direct or
// vectored), new privilege, updated status word and trap value, and flags a
// reserved vector mode or a reserved current privilege. Rate: one beat per
// cycle sustained while out_stall does not hold the result; a beat passes
// through the input register, single-pass logic and the result register. The
// input register can still take a beat while a finished result waits on
// out_stall, so the block only stalls its input once both registers are full.
// Configuration registers reset to zero and must be written only while the
// block is idle.
module riscv_trap_entry_and_interrupt_select_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_cause_code,
  input  logic        in_is_interrupt,
  input  logic [31:0] in_fault_pc,
  input  logic [31:0] in_fault_value,
  input  logic [1:0]  in_cur_priv,
  input  logic [31:0] in_cur_status,
  input  logic [11:0] in_pending,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_irq_valid,
  output logic [4:0]  out_irq_cause,
  output logic        out_global_enable,
  output logic        out_to_supervisor,
  output logic [31:0] out_trap_pc,
  output logic [1:0]  out_new_priv,
  output logic [31:0] out_new_status,
  output logic [31:0] out_saved_value,
  output logic [1:0]  out_trap_error
);
  import rtsel_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  item_t   item_nxt;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  result_t res;
  result_t res_r;
  result_t res_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    s2_ready;
  logic    s1_ready;

  rtsel_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Result register frees when empty or when its beat is taken
  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  always_comb begin
    item_nxt     = item_r;
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = in_valid;
      if (in_valid) begin
        item_nxt.kind         = in_kind;
        item_nxt.cause_code   = in_cause_code;
        item_nxt.is_interrupt = in_is_interrupt;
        item_nxt.fault_pc     = in_fault_pc;
        item_nxt.fault_value  = in_fault_value;
        item_nxt.cur_priv     = in_cur_priv;
        item_nxt.cur_status   = in_cur_status;
        item_nxt.pending      = in_pending;
      end
    end
  end

  rtsel_trap_eval u_eval (
    .item (item_r),
    .cfg  (cfg),
    .res  (res)
  );

  // Advance into the result register; drop unused-kind beats here
  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r && (item_r.kind != KIND_UNUSED);
      if (s1_valid_r) begin
        res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_irq_valid     = res_r.irq_valid;
  assign out_irq_cause     = res_r.irq_cause;
  assign out_global_enable = res_r.global_enable;
  assign out_to_supervisor = res_r.to_supervisor;
  assign out_trap_pc       = res_r.trap_pc;
  assign out_new_priv      = res_r.new_priv;
  assign out_new_status    = res_r.new_status;
  assign out_saved_value   = res_r.saved_value;
  assign out_trap_error    = res_r.trap_error;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while a register is free");

  a_rsv_priv_disables: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_trap_error == ERR_PRIV)) |-> (!out_global_enable && !out_irq_valid))
    else $error("reserved privilege reported with enable or interrupt");

  a_irq_is_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq_valid) |-> (!out_to_supervisor && (out_trap_error == ERR_NONE)
                                      && (out_new_priv == PRIV_U)))
    else $error("query result carries trap fields");

  a_sup_priv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_to_supervisor) |-> (out_new_priv == PRIV_S))
    else $error("supervisor trap without supervisor privilege");
`endif

endmodule
